// ===== rtl/stcd_pkg.sv =====
// Shared types and constants of the STUN / ChannelData TCP deframer.
package stcd_pkg;

   localparam int STUN_HDR_BYTES_DEF = 20;
   localparam int QUEUE_DEPTH_DEF    = 4;

   localparam logic [15:0] TYPE_CHANNEL_MIN = 16'h4000;
   localparam logic [15:0] TYPE_BAD_MIN     = 16'h8000;
   localparam logic [1:0]  WORD_MASK        = 2'b11;
   localparam int          CHAN_HDR_BYTES   = 4;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_PAD    = 2'd2,
      PH_HALT   = 2'd3
   } stcd_phase_type;

   // One queue entry: up to four result bytes that leave in order.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      num;    // index of the final byte in data
      logic            first;  // applies to data[0]
      logic            last;   // applies to data[num]
      logic            chan;
      logic            bad;
   } stcd_entry_type;

   typedef struct packed {
      logic           valid;
      stcd_entry_type entry;
   } stcd_slot_type;

endpackage

// ===== rtl/stun_channel_tcp_deframer_top.sv =====
// Top level of the STUN / ChannelData deframer for a TURN-over-TCP byte stream.
//
// Input channel (req_): one byte of the TCP stream per transaction. Output
// channel (rsp_): one byte of a framed message per transaction, with marks
// for the first header byte and the last message byte, the message kind and
// an error flag. Both channels use valid/ready.
//
// The first three header bytes of each message are held back; with the fourth
// the type and length are decoded and the four header bytes leave as four
// consecutive transactions. Body bytes follow one per transaction; padding to
// the next 4-byte boundary is dropped. A type of 0x8000 or above gives one
// error transaction and the block then swallows every byte until reset.
//
// Throughput: one input byte per cycle. The front end takes a byte each
// cycle unless the group queue is full; the back end issues one byte each
// cycle while the receiver is ready, so a header group of four bytes takes
// four output transactions. A byte that completes a header or carries body
// data goes through the queue into the output register that drives rsp_valid.
// Reset (synchronous) empties the queue and the output register and returns
// to header capture. When the receiver stalls, the output register holds,
// the queue fills, and then req_ready drops on bytes that produce results.
module stun_channel_tcp_deframer_top #(
   parameter int STUN_HDR_BYTES = stcd_pkg::STUN_HDR_BYTES_DEF,
   parameter int QUEUE_DEPTH    = stcd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_first,
   output logic       rsp_frame_last,
   output logic       rsp_is_channel,
   output logic       rsp_bad_type
);
   import stcd_pkg::*;

   stcd_slot_type push;
   stcd_slot_type head;
   logic          queue_full;
   logic          pop;

   // classify bytes and build result groups
   stcd_front #(
      .STUN_HDR_BYTES (STUN_HDR_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stream_byte (req_stream_byte),
      .req_ready       (req_ready),
      .queue_full      (queue_full),
      .push            (push)
   );

   // decouple parsing from output stalls
   stcd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // hand groups out one byte at a time
   stcd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_first (rsp_frame_first),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_is_channel  (rsp_is_channel),
      .rsp_bad_type    (rsp_bad_type)
   );

endmodule

// ===== rtl/stcd_front.sv =====
// Front end: header capture, message classification and length tracking.
module stcd_front #(
   parameter int STUN_HDR_BYTES = stcd_pkg::STUN_HDR_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_stream_byte,
   output logic                   req_ready,
   input  logic                   queue_full,
   output stcd_pkg::stcd_slot_type push
);
   import stcd_pkg::*;

   stcd_phase_type phase_ff, phase_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic [7:0]     hdr_ff [3];
   logic [7:0]     hdr_in [3];
   logic [16:0]    left_ff, left_in;
   logic [1:0]     pad_ff, pad_in;
   logic           chan_ff, chan_in;

   logic [15:0] msg_type;
   logic [15:0] msg_len;
   logic        type_chan;
   logic [16:0] body_len;
   logic [1:0]  body_pad;
   logic        need_push;
   logic        accept;

   assign msg_type  = {hdr_ff[0], hdr_ff[1]};
   assign msg_len   = {hdr_ff[2], req_stream_byte};
   assign type_chan = (msg_type >= TYPE_CHANNEL_MIN);
   assign body_len  = type_chan ? {1'b0, msg_len}
                                : {1'b0, msg_len} + 17'(STUN_HDR_BYTES - CHAN_HDR_BYTES);
   // header is a multiple of four, so the body alone sets the padding
   assign body_pad  = (2'd0 - body_len[1:0]) & WORD_MASK;

   assign need_push = (phase_ff == PH_BODY) || (phase_ff == PH_HEADER && cnt_ff == 2'd3);
   assign req_ready = !need_push || !queue_full;
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      hdr_in   = hdr_ff;
      left_in  = left_ff;
      pad_in   = pad_ff;
      chan_in  = chan_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (cnt_ff != 2'd3) begin
                  hdr_in[cnt_ff] = req_stream_byte;
                  cnt_in         = cnt_ff + 2'd1;
               end else begin
                  cnt_in = 2'd0;
                  if (msg_type >= TYPE_BAD_MIN) begin
                     phase_in = PH_HALT;
                  end else begin
                     chan_in = type_chan;
                     left_in = body_len;
                     pad_in  = body_pad;
                     if (body_len != 17'd0) begin
                        phase_in = PH_BODY;
                     end else begin
                        phase_in = (body_pad != 2'd0) ? PH_PAD : PH_HEADER;
                     end
                  end
               end
            end
            PH_BODY: begin
               if (left_ff <= 17'd1) begin
                  left_in  = 17'd0;
                  phase_in = (pad_ff != 2'd0) ? PH_PAD : PH_HEADER;
               end else begin
                  left_in = left_ff - 17'd1;
               end
            end
            PH_PAD: begin
               pad_in = (pad_ff != 2'd0) ? pad_ff - 2'd1 : 2'd0;
               if (pad_ff <= 2'd1) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HALT: begin
               phase_in = PH_HALT;
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end
   end

   // queue push
   always_comb begin
      push             = '0;
      push.valid       = accept && need_push;
      push.entry.chan  = (phase_ff == PH_HEADER) ? type_chan : chan_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (msg_type >= TYPE_BAD_MIN) begin
               push.entry.bad  = 1'b1;
               push.entry.chan = 1'b0;
            end else begin
               push.entry.data  = {req_stream_byte, hdr_ff[2], hdr_ff[1], hdr_ff[0]};
               push.entry.num   = 2'd3;
               push.entry.first = 1'b1;
               push.entry.last  = (body_len == 17'd0);
            end
         end
         PH_BODY: begin
            push.entry.data[0] = req_stream_byte;
            push.entry.last    = (left_ff <= 17'd1);
         end
         default: begin
            push.entry.chan = chan_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         cnt_ff   <= 2'd0;
         left_ff  <= 17'd0;
         pad_ff   <= 2'd0;
         chan_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         pad_ff   <= pad_in;
         chan_ff  <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT))
      else $error("halted deframer left the halt phase");

   a_count_in_header: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> (phase_ff == PH_HEADER))
      else $error("header bytes held outside the header phase");

endmodule

// ===== rtl/stcd_queue.sv =====
// Short queue of result groups between front and back ends.
module stcd_queue #(
   parameter int QUEUE_DEPTH = stcd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stcd_pkg::stcd_slot_type push,
   output logic                    full,
   output stcd_pkg::stcd_slot_type head,
   input  logic                    pop
);
   import stcd_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   stcd_entry_type mem_ff [QUEUE_DEPTH];
   logic [AW:0]    wr_ff, wr_in;
   logic [AW:0]    rd_ff, rd_in;
   logic           empty;

   assign empty      = (wr_ff == rd_ff);
   assign full       = (wr_ff[AW] != rd_ff[AW]) && (wr_ff[AW-1:0] == rd_ff[AW-1:0]);
   assign head.valid = !empty;
   assign head.entry = mem_ff[rd_ff[AW-1:0]];

   // advance pointers; wrap past the depth when it is not a power of two
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push.valid && !full) begin
         wr_in = (wr_ff[AW-1:0] == AW'(QUEUE_DEPTH - 1))
               ? {~wr_ff[AW], {AW{1'b0}}} : wr_ff + (AW+1)'(1);
      end
      if (pop && !empty) begin
         rd_in = (rd_ff[AW-1:0] == AW'(QUEUE_DEPTH - 1))
               ? {~rd_ff[AW], {AW{1'b0}}} : rd_ff + (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid && !full) begin
         mem_ff[wr_ff[AW-1:0]] <= push.entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("transaction pushed into a full queue");

endmodule

// ===== rtl/stcd_back.sv =====
// Back end: split queued groups into single result bytes behind an output register.
module stcd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  stcd_pkg::stcd_slot_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_frame_first,
   output logic                    rsp_frame_last,
   output logic                    rsp_is_channel,
   output logic                    rsp_bad_type
);
   import stcd_pkg::*;

   logic [1:0] sub_ff, sub_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       first_ff, last_ff, chan_ff, bad_ff;
   logic       load;
   logic       final_byte;

   assign load       = head.valid && (!valid_ff || rsp_ready);
   assign final_byte = (sub_ff == head.entry.num);
   assign pop        = load && final_byte;

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      if (load) begin
         valid_in = 1'b1;
         sub_in   = final_byte ? 2'd0 : sub_ff + 2'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= head.entry.data[sub_ff];
         first_ff <= head.entry.first && (sub_ff == 2'd0);
         last_ff  <= head.entry.last && final_byte;
         chan_ff  <= head.entry.chan;
         bad_ff   <= head.entry.bad;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_byte  = byte_ff;
   assign rsp_frame_first = first_ff;
   assign rsp_frame_last  = last_ff;
   assign rsp_is_channel  = chan_ff;
   assign rsp_bad_type    = bad_ff;

   a_sub_in_group: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> (sub_ff <= head.entry.num))
      else $error("byte index ran past its group");

   a_bad_plain: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && bad_ff) |-> (!first_ff && !last_ff && !chan_ff && byte_ff == 8'd0))
      else $error("error transaction carries message marks");

endmodule
